### hdl/ffba_pkg.sv
// Shared types, constants and helper functions of the first-fit block allocator.
// No dependencies.
`timescale 1ns / 1ps
package ffba_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = IDX_W + 1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [2:0] KIND_FREE    = 3'd0;
  localparam logic [2:0] KIND_BUFFER  = 3'd1;
  localparam logic [2:0] KIND_IMAGE   = 3'd2;
  localparam logic [2:0] KIND_LINEAR  = 3'd3;
  localparam logic [2:0] KIND_OPTIMAL = 3'd4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic CFG_POOL = 1'b0;
  localparam logic CFG_GRAN = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOSPC  = 2'd1;
  localparam logic [1:0] ST_BADID  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
    logic [31:0] payload;
    logic [2:0]  kind;
    logic [15:0] tag;
  } entry_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    entry_t wdata;
    idx_t   raddr;
  } mem_req_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_PRE,
    S_A_RD, S_A_CAP, S_A_ALN, S_A_PUSH, S_A_PAD, S_A_CHK, S_A_NRD, S_A_NCAP,
    S_A_SPLIT, S_A_WNEW, S_A_WCUR,
    S_F_RD, S_F_CAP, S_F_NRD, S_F_NCAP, S_F_M1, S_F_M2,
    S_SH_RD, S_SH_WR, S_DONE
  } state_t;

  function automatic logic [16:0] pow2_floor(input logic [16:0] v);
    logic [16:0] r;
    r = 17'd1;
    for (int b = 0; b < 17; b++) begin
      if (v[b]) r = 17'd1 << b;
    end
    return r;
  endfunction

  function automatic logic [33:0] align_up(input logic [33:0] x, input logic [16:0] a);
    logic [33:0] m;
    m = {17'd0, a} - 34'd1;
    return (x + m) & ~m;
  endfunction

  function automatic logic same_page(input logic [33:0] a_end, input logic [33:0] b,
                                     input logic [16:0] page);
    logic [33:0] m;
    m = {17'd0, page} - 34'd1;
    return (a_end & ~m) == (b & ~m);
  endfunction

  function automatic logic kinds_conflict(input logic [2:0] x, input logic [2:0] y);
    logic [2:0] a;
    logic [2:0] b;
    logic       r;
    a = (x > y) ? y : x;
    b = (x > y) ? x : y;
    case (a)
      KIND_BUFFER: r = (b == KIND_IMAGE) || (b == KIND_OPTIMAL);
      KIND_IMAGE:  r = (b == KIND_IMAGE) || (b == KIND_LINEAR) || (b == KIND_OPTIMAL);
      KIND_LINEAR: r = (b == KIND_OPTIMAL);
      default:     r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### hdl/ffba_if.sv
// Request and response channel interfaces of the allocator.
// No dependencies.
`timescale 1ns / 1ps
interface ffba_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] req_bytes;
  logic [16:0] req_align;
  logic [2:0]  req_kind;
  logic [15:0] free_handle;
  modport source (output valid, opcode, req_bytes, req_align, req_kind, free_handle,
                  input ready);
  modport sink   (input valid, opcode, req_bytes, req_align, req_kind, free_handle,
                  output ready);
endinterface

interface ffba_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] alloc_offset;
  logic [15:0] alloc_handle;
  logic [31:0] bytes_used;
  modport source (output valid, status, alloc_offset, alloc_handle, bytes_used,
                  input ready);
  modport sink   (input valid, status, alloc_offset, alloc_handle, bytes_used,
                  output ready);
endinterface

### hdl/ffba_table.sv
// Block table memory: one write port, one registered read port.
// Depends on ffba_pkg.
`timescale 1ns / 1ps
module ffba_table (
  input  logic                clk,
  input  ffba_pkg::mem_req_t  mreq,
  output ffba_pkg::entry_t    rdata
);

  ffba_pkg::entry_t mem [ffba_pkg::MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (mreq.we) mem[mreq.waddr] <= mreq.wdata;
    rdata <= mem[mreq.raddr];
  end

endmodule

### hdl/ffba_ctrl.sv
// Sequencer and shared arithmetic of the allocator: scan, split, merge, shift.
// Depends on ffba_pkg and ffba_if.
`timescale 1ns / 1ps
module ffba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  ffba_req_if.sink           req,
  ffba_rsp_if.source         rsp,
  output ffba_pkg::mem_req_t mreq,
  input  ffba_pkg::entry_t   rdata
);

  ffba_pkg::state_t state, state_next;
  logic [31:0] pool, pool_next;
  logic [16:0] gran, gran_next;
  ffba_pkg::cnt_t count, count_next;
  logic [15:0] tag, tag_next;
  logic [31:0] alloc, alloc_next;
  logic        op, op_next;
  logic [31:0] size, size_next;
  logic [16:0] align, align_next;
  logic [2:0]  kind, kind_next;
  logic [15:0] handle, handle_next;
  ffba_pkg::cnt_t i, i_next;
  ffba_pkg::cnt_t src, src_next;
  ffba_pkg::cnt_t dst, dst_next;
  logic [1:0]  k, k_next;
  logic        up, up_next;
  ffba_pkg::entry_t cur, cur_next, prev, prev_next, nxt, nxt_next;
  logic [33:0] aligned, aligned_next;
  logic [33:0] padded, padded_next;
  logic [31:0] sum, sum_next;
  logic [1:0]  res_status, res_status_next;
  logic [31:0] res_off, res_off_next;
  logic [15:0] res_handle, res_handle_next;
  logic        ov, ov_next;
  logic [1:0]  o_status, o_status_next;
  logic [31:0] o_off, o_off_next;
  logic [15:0] o_handle, o_handle_next;
  logic [31:0] o_used, o_used_next;

  logic mp, mn;
  ffba_pkg::cnt_t w;

  assign mp = (i != '0) && (prev.kind == ffba_pkg::KIND_FREE);
  assign mn = ((i + 1'b1) < count) && (nxt.kind == ffba_pkg::KIND_FREE);
  assign w  = mp ? i - 1'b1 : i;

  assign req.ready        = (state == ffba_pkg::S_IDLE);
  assign rsp.valid        = ov;
  assign rsp.status       = o_status;
  assign rsp.alloc_offset = o_off;
  assign rsp.alloc_handle = o_handle;
  assign rsp.bytes_used   = o_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffba_pkg::S_INIT;
      pool  <= 32'd1048576;
      gran  <= 17'd1;
      count <= ffba_pkg::CNT_W'(1);
      tag   <= 16'd1;
      alloc <= '0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      pool  <= pool_next;
      gran  <= gran_next;
      count <= count_next;
      tag   <= tag_next;
      alloc <= alloc_next;
      ov    <= ov_next;
    end
    op <= op_next; size <= size_next; align <= align_next; kind <= kind_next;
    handle <= handle_next; i <= i_next; src <= src_next; dst <= dst_next;
    k <= k_next; up <= up_next; cur <= cur_next; prev <= prev_next; nxt <= nxt_next;
    aligned <= aligned_next; padded <= padded_next; sum <= sum_next;
    res_status <= res_status_next; res_off <= res_off_next; res_handle <= res_handle_next;
    o_status <= o_status_next; o_off <= o_off_next; o_handle <= o_handle_next;
    o_used <= o_used_next;
  end

  always_comb begin
    state_next = state; pool_next = pool; gran_next = gran; count_next = count;
    tag_next = tag; alloc_next = alloc; ov_next = ov;
    op_next = op; size_next = size; align_next = align; kind_next = kind;
    handle_next = handle; i_next = i; src_next = src; dst_next = dst; k_next = k;
    up_next = up; cur_next = cur; prev_next = prev; nxt_next = nxt;
    aligned_next = aligned; padded_next = padded; sum_next = sum;
    res_status_next = res_status; res_off_next = res_off; res_handle_next = res_handle;
    o_status_next = o_status; o_off_next = o_off; o_handle_next = o_handle;
    o_used_next = o_used;
    mreq.we    = 1'b0;
    mreq.waddr = '0;
    mreq.wdata = '0;
    mreq.raddr = i[ffba_pkg::IDX_W-1:0];

    if (ov && rsp.ready) ov_next = 1'b0;

    unique case (state)
      ffba_pkg::S_INIT: begin
        mreq.we           = 1'b1;
        mreq.wdata.length = pool;
        mreq.wdata.kind   = ffba_pkg::KIND_FREE;
        state_next        = ffba_pkg::S_IDLE;
      end
      ffba_pkg::S_IDLE: begin
        if (req.valid) begin
          op_next = req.opcode; size_next = req.req_bytes;
          align_next = ffba_pkg::pow2_floor(req.req_align);
          kind_next = req.req_kind; handle_next = req.free_handle;
          state_next = ffba_pkg::S_PRE;
        end
      end
      ffba_pkg::S_PRE: begin
        i_next = '0;
        res_off_next = '0;
        res_handle_next = '0;
        res_status_next = ffba_pkg::ST_OK;
        if (op == ffba_pkg::OP_FREE) begin
          state_next = ffba_pkg::S_F_RD;
        end else if (size == '0 || kind < ffba_pkg::KIND_BUFFER ||
                     kind > ffba_pkg::KIND_OPTIMAL || pool < alloc ||
                     (pool - alloc) < size) begin
          res_status_next = ffba_pkg::ST_NOSPC;
          state_next = ffba_pkg::S_DONE;
        end else begin
          state_next = ffba_pkg::S_A_RD;
        end
      end
      ffba_pkg::S_A_RD: state_next = ffba_pkg::S_A_CAP;
      ffba_pkg::S_A_CAP: begin
        cur_next = rdata;
        if (rdata.kind != ffba_pkg::KIND_FREE || rdata.length < size) begin
          prev_next = rdata;
          i_next = i + 1'b1;
          if (i + 1'b1 == count) begin
            res_status_next = ffba_pkg::ST_NOSPC;
            state_next = ffba_pkg::S_DONE;
          end else begin
            state_next = ffba_pkg::S_A_RD;
          end
        end else begin
          state_next = ffba_pkg::S_A_ALN;
        end
      end
      ffba_pkg::S_A_ALN: begin
        aligned_next = ffba_pkg::align_up({2'b00, cur.start}, align);
        state_next = ffba_pkg::S_A_PUSH;
      end
      ffba_pkg::S_A_PUSH: begin
        if (i != '0 && gran > 17'd1 &&
            ffba_pkg::same_page({2'b00, prev.start} + {2'b00, prev.length} - 34'd1,
                                aligned, gran) &&
            ffba_pkg::kinds_conflict(prev.kind, kind))
          aligned_next = ffba_pkg::align_up(aligned, gran);
        state_next = ffba_pkg::S_A_PAD;
      end
      ffba_pkg::S_A_PAD: begin
        padded_next = aligned - {2'b00, cur.start} + {2'b00, size};
        state_next = ffba_pkg::S_A_CHK;
      end
      ffba_pkg::S_A_CHK: begin
        if (padded > {2'b00, cur.length}) begin
          prev_next = cur;
          i_next = i + 1'b1;
          if (i + 1'b1 == count) begin
            res_status_next = ffba_pkg::ST_NOSPC;
            state_next = ffba_pkg::S_DONE;
          end else begin
            state_next = ffba_pkg::S_A_RD;
          end
        end else if (({1'b0, padded} + {3'b000, alloc}) > {3'b000, pool}) begin
          res_status_next = ffba_pkg::ST_NOSPC;
          state_next = ffba_pkg::S_DONE;
        end else if (gran > 17'd1 && (i + 1'b1) < count) begin
          state_next = ffba_pkg::S_A_NRD;
        end else begin
          state_next = ffba_pkg::S_A_SPLIT;
        end
      end
      ffba_pkg::S_A_NRD: begin
        mreq.raddr = ffba_pkg::IDX_W'(i + 1'b1);
        state_next = ffba_pkg::S_A_NCAP;
      end
      ffba_pkg::S_A_NCAP: begin
        if (ffba_pkg::same_page(aligned + {2'b00, size} - 34'd1, {2'b00, rdata.start}, gran)
            && ffba_pkg::kinds_conflict(kind, rdata.kind)) begin
          prev_next = cur;
          i_next = i + 1'b1;
          if (i + 1'b1 == count) begin
            res_status_next = ffba_pkg::ST_NOSPC;
            state_next = ffba_pkg::S_DONE;
          end else begin
            state_next = ffba_pkg::S_A_RD;
          end
        end else begin
          state_next = ffba_pkg::S_A_SPLIT;
        end
      end
      ffba_pkg::S_A_SPLIT: begin
        if ({2'b00, cur.length} > padded) begin
          if (count >= ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS)) begin
            res_status_next = ffba_pkg::ST_FULL;
            state_next = ffba_pkg::S_DONE;
          end else if (count > i + 1'b1) begin
            up_next = 1'b1;
            dst_next = count;
            src_next = count - 1'b1;
            state_next = ffba_pkg::S_SH_RD;
          end else begin
            state_next = ffba_pkg::S_A_WNEW;
          end
        end else begin
          state_next = ffba_pkg::S_A_WCUR;
        end
      end
      ffba_pkg::S_A_WNEW: begin
        mreq.we = 1'b1;
        mreq.waddr = ffba_pkg::IDX_W'(i + 1'b1);
        mreq.wdata.start = cur.start + padded[31:0];
        mreq.wdata.length = cur.length - padded[31:0];
        mreq.wdata.payload = '0;
        mreq.wdata.kind = ffba_pkg::KIND_FREE;
        mreq.wdata.tag = tag;
        tag_next = tag + 16'd1;
        count_next = count + 1'b1;
        state_next = ffba_pkg::S_A_WCUR;
      end
      ffba_pkg::S_A_WCUR: begin
        mreq.we = 1'b1;
        mreq.waddr = i[ffba_pkg::IDX_W-1:0];
        mreq.wdata.start = cur.start;
        mreq.wdata.length = padded[31:0];
        mreq.wdata.payload = size;
        mreq.wdata.kind = kind;
        mreq.wdata.tag = cur.tag;
        alloc_next = alloc + padded[31:0];
        res_off_next = aligned[31:0];
        res_handle_next = cur.tag;
        state_next = ffba_pkg::S_DONE;
      end
      ffba_pkg::S_F_RD: state_next = ffba_pkg::S_F_CAP;
      ffba_pkg::S_F_CAP: begin
        if (rdata.tag == handle) begin
          cur_next = rdata;
          state_next = ((i + 1'b1) < count) ? ffba_pkg::S_F_NRD : ffba_pkg::S_F_M1;
        end else begin
          prev_next = rdata;
          i_next = i + 1'b1;
          if (i + 1'b1 == count) begin
            res_status_next = ffba_pkg::ST_BADID;
            state_next = ffba_pkg::S_DONE;
          end else begin
            state_next = ffba_pkg::S_F_RD;
          end
        end
      end
      ffba_pkg::S_F_NRD: begin
        mreq.raddr = ffba_pkg::IDX_W'(i + 1'b1);
        state_next = ffba_pkg::S_F_NCAP;
      end
      ffba_pkg::S_F_NCAP: begin
        nxt_next = rdata;
        state_next = ffba_pkg::S_F_M1;
      end
      ffba_pkg::S_F_M1: begin
        sum_next = cur.length + (mn ? nxt.length : 32'd0);
        alloc_next = (alloc > cur.payload) ? alloc - cur.payload : 32'd0;
        state_next = ffba_pkg::S_F_M2;
      end
      ffba_pkg::S_F_M2: begin
        mreq.we = 1'b1;
        mreq.waddr = w[ffba_pkg::IDX_W-1:0];
        mreq.wdata.payload = '0;
        mreq.wdata.kind = ffba_pkg::KIND_FREE;
        if (mp) begin
          mreq.wdata.start = prev.start;
          mreq.wdata.length = sum + prev.length;
          mreq.wdata.tag = prev.tag;
        end else begin
          mreq.wdata.start = cur.start;
          mreq.wdata.length = sum;
          mreq.wdata.tag = cur.tag;
        end
        k_next = {1'b0, mp} + {1'b0, mn};
        up_next = 1'b0;
        dst_next = w + 1'b1;
        src_next = w + 1'b1 + ffba_pkg::CNT_W'({1'b0, mp} + {1'b0, mn});
        if ((w + 1'b1 + ffba_pkg::CNT_W'({1'b0, mp} + {1'b0, mn})) < count &&
            (mp || mn)) begin
          state_next = ffba_pkg::S_SH_RD;
        end else begin
          count_next = count - ffba_pkg::CNT_W'({1'b0, mp} + {1'b0, mn});
          state_next = ffba_pkg::S_DONE;
        end
      end
      ffba_pkg::S_SH_RD: begin
        mreq.raddr = src[ffba_pkg::IDX_W-1:0];
        state_next = ffba_pkg::S_SH_WR;
      end
      ffba_pkg::S_SH_WR: begin
        mreq.we = 1'b1;
        mreq.waddr = dst[ffba_pkg::IDX_W-1:0];
        mreq.wdata = rdata;
        if (up) begin
          dst_next = dst - 1'b1;
          src_next = src - 1'b1;
          state_next = ((dst - 1'b1) > (i + 1'b1)) ? ffba_pkg::S_SH_RD
                                                   : ffba_pkg::S_A_WNEW;
        end else begin
          dst_next = dst + 1'b1;
          src_next = src + 1'b1;
          if ((src + 1'b1) < count) begin
            state_next = ffba_pkg::S_SH_RD;
          end else begin
            count_next = count - ffba_pkg::CNT_W'(k);
            state_next = ffba_pkg::S_DONE;
          end
        end
      end
      ffba_pkg::S_DONE: begin
        if (!ov || rsp.ready) begin
          ov_next = 1'b1;
          o_status_next = res_status;
          o_off_next = (res_status == ffba_pkg::ST_OK) ? res_off : 32'd0;
          o_handle_next = (res_status == ffba_pkg::ST_OK) ? res_handle : 16'd0;
          o_used_next = alloc;
          state_next = ffba_pkg::S_IDLE;
        end
      end
      default: state_next = ffba_pkg::S_IDLE;
    endcase

    if (cfg_we) begin
      if (cfg_index == ffba_pkg::CFG_POOL) begin
        pool_next = cfg_data;
        count_next = ffba_pkg::CNT_W'(1);
        tag_next = 16'd1;
        alloc_next = '0;
        mreq.we = 1'b1;
        mreq.waddr = '0;
        mreq.wdata = '0;
        mreq.wdata.length = cfg_data;
        mreq.wdata.kind = ffba_pkg::KIND_FREE;
      end else begin
        gran_next = ffba_pkg::pow2_floor(cfg_data[16:0]);
      end
    end
  end

endmodule

### hdl/first_fit_block_allocator.sv
// First-fit block allocator with coalescing: sequencer plus block table.
// Depends on ffba_pkg, ffba_if, ffba_table and ffba_ctrl.
//
// Requests arrive on req (valid/ready): opcode 0 allocates req_bytes at
// req_align for req_kind, opcode 1 frees the block with id free_handle.
// Each request yields one response on rsp: status, offset, id, bytes in use.
// Configuration: cfg_we with cfg_index 0 sets the pool size and resets the
// table to one free block; index 1 sets the page granularity.
// One request at a time. An allocate scans the table entry by entry,
// skipping entries in use or too small; a free entry is tested by aligning,
// pushing past a page conflict with the previous entry and padding, and the
// next entry is read for a page conflict when the granularity is above one.
// Entries are moved one by one when a split inserts a block. A free scans
// entry by entry up to the match, then moves entries one by one when a merge
// removes blocks; the single read port of the table makes all of this serial.
// After reset, the S_INIT state writes the initial free block before req is ready.
// The response is held in an output register; the next request is taken
// while it waits, and its result waits in turn until rsp is taken.
`timescale 1ns / 1ps
module first_fit_block_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  ffba_req_if.sink    req,
  ffba_rsp_if.source  rsp
);

  ffba_pkg::mem_req_t mreq;
  ffba_pkg::entry_t   rdata;

  ffba_table u_table (
    .clk   (clk),
    .mreq  (mreq),
    .rdata (rdata)
  );

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp),
    .mreq      (mreq),
    .rdata     (rdata)
  );

endmodule
